[hdl/hermite_edge_point_eval_top_macros.svh]
// ----------------------------------------------------------------------------
// Hermite edge point evaluator assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HERMITE_EDGE_POINT_EVAL_TOP_MACROS_SVH
`define HERMITE_EDGE_POINT_EVAL_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define HEPE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hepe assertion failed");
// next-cycle implication
`define HEPE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hepe assertion failed");
`else
`define HEPE_ASSERT_SAME(label, ante, cons)
`define HEPE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/hepe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hermite edge point evaluator package
// Widths, fixed-point constants and codes shared by the evaluator.
// ----------------------------------------------------------------------------
package hepe_pkg;

   localparam int THETA_BITS = 16;              // fraction bits of theta and coefficients
   localparam int THETA_FW   = 17;              // theta field width
   localparam int COORD_W    = 32;              // coordinate / tangent width
   localparam int NUM_COORD  = 8;               // coordinate fields per transaction
   localparam int NSTG       = 6;               // pipeline stages

   localparam int T_W  = THETA_BITS + 1;        // t, u, t^2, u^2
   localparam int P_W  = 2 * T_W;               // t*t, u*u, u2*t, t2*u
   localparam int K_W  = T_W + 1;               // 3*ONE - 2*t
   localparam int PK_W = T_W + K_W;             // t2*(3*ONE - 2*t)
   localparam int C_W  = T_W + 1;               // signed blend coefficient
   localparam int PR_W = COORD_W + C_W;         // coordinate * coefficient
   localparam int S_W  = PR_W + 2;              // four-term sum
   localparam int R_W  = S_W - THETA_BITS;      // rounded sum

   localparam int IN_W        = THETA_FW + NUM_COORD * COORD_W;
   localparam int REQ_TDATA_W = ((IN_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = 2 * COORD_W;

   localparam logic [T_W-1:0]        ONE   = T_W'(1) << THETA_BITS;
   localparam logic signed [C_W-1:0] ONE_C = C_W'(1) << THETA_BITS;

   // coordinate slots, x at the slot, y at slot + 1
   localparam int PT_START = 0;
   localparam int PT_END   = 2;
   localparam int PT_TS    = 4;
   localparam int PT_TE    = 6;

   // blend mode, {has_tangent_end, has_tangent_start}
   localparam logic [1:0] MODE_LINEAR  = 2'b00;
   localparam logic [1:0] MODE_START   = 2'b01;
   localparam logic [1:0] MODE_END     = 2'b10;
   localparam logic [1:0] MODE_HERMITE = 2'b11;

endpackage

[hdl/hermite_edge_point_eval_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hermite edge point evaluator
// Evaluates one point of a 2D curve edge per transaction in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transaction carries theta (0..65536 = 0..1.0, larger is
//    clamped to 1.0), both end points and both end tangents in tdata, and the
//    two tangent-present flags in tuser. The flags pick linear, start-sided
//    quadratic, end-sided quadratic or cubic Hermite blending.
//  - rsp channel: one transaction per request, in order: point x/y in tdata
//    (Q16.16, rounded half up, clipped to int32) and the saturated flag in tuser.
//  - Pipeline: six register stages lie between the accepting edge and
//    rsp_tvalid; the first loads at the accepting edge.
//  - Throughput: one transaction per cycle while rsp_tready is high, through
//    the six-stage pipeline (t^2 / u^2, cubic terms, coefficient select,
//    coordinate products, pair sums, final sum with round and clip).
//  - Each stage has its own valid bit and loads whenever it is empty or the
//    stage after it moves, so bubbles close up when rsp_tready is low and
//    req_tready drops only once every stage holds a transaction.
//  - Reset (synchronous) clears all valid bits and holds req_tready low;
//    the data registers are not reset.
// ----------------------------------------------------------------------------
`include "hermite_edge_point_eval_top_macros.svh"

module hermite_edge_point_eval_top
   import hepe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // theta, start_x, start_y, end_x, end_y, tangent_start_x, tangent_start_y,
   // tangent_end_x, tangent_end_y, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // has_tangent_start, has_tangent_end
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // point_x, point_y
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // saturated
   output logic [0:0]             rsp_tuser
);

   // ---------------- stage control ----------------
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] rdy;

   always_comb begin
      rdy[NSTG-1] = !vld_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_tready = rdy[0] && !reset;

   // ---------------- stage 1: clamp, t*t and u*u ----------------
   logic [THETA_FW-1:0]      theta_in;
   logic [T_W-1:0]           t1_in, u1_in;
   logic signed [COORD_W-1:0] crd_in [NUM_COORD];

   logic [T_W-1:0]            t1_ff, u1_ff;
   logic [P_W-1:0]            tt1_ff, uu1_ff;
   logic [1:0]                mode1_ff;
   logic signed [COORD_W-1:0] crd1_ff [NUM_COORD];

   always_comb begin
      theta_in = req_tdata[THETA_FW-1:0];
      t1_in    = (theta_in > THETA_FW'(ONE)) ? ONE : T_W'(theta_in);
      u1_in    = ONE - t1_in;
      for (int i = 0; i < NUM_COORD; i++) begin
         crd_in[i] = $signed(req_tdata[THETA_FW + i*COORD_W +: COORD_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         t1_ff    <= t1_in;
         u1_ff    <= u1_in;
         tt1_ff   <= P_W'(t1_in) * P_W'(t1_in);
         uu1_ff   <= P_W'(u1_in) * P_W'(u1_in);
         mode1_ff <= {req_tuser[1], req_tuser[0]};
         crd1_ff  <= crd_in;
      end
   end

   // ---------------- stage 2: t2, u2 and cubic terms ----------------
   logic [T_W-1:0] t2_in, u2_in;
   logic [K_W-1:0] k3_in;

   logic [T_W-1:0]            t2_ff, u2_ff, tq2_ff, uq2_ff;
   logic [PK_W-1:0]           pcb2_ff;
   logic [P_W-1:0]            pcta2_ff, pctb2_ff;
   logic [1:0]                mode2_ff;
   logic signed [COORD_W-1:0] crd2_ff [NUM_COORD];

   always_comb begin
      t2_in = T_W'((tt1_ff + (P_W'(1) << (THETA_BITS - 1))) >> THETA_BITS);
      u2_in = T_W'((uu1_ff + (P_W'(1) << (THETA_BITS - 1))) >> THETA_BITS);
      // 3*ONE - 2*t, never negative for t <= ONE
      k3_in = (K_W'(ONE) << 1) + K_W'(ONE) - (K_W'(t1_ff) << 1);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         t2_ff    <= t1_ff;
         u2_ff    <= u1_ff;
         tq2_ff   <= t2_in;
         uq2_ff   <= u2_in;
         pcb2_ff  <= PK_W'(t2_in) * PK_W'(k3_in);
         pcta2_ff <= P_W'(u2_in) * P_W'(t1_ff);
         pctb2_ff <= P_W'(t2_in) * P_W'(u1_ff);
         mode2_ff <= mode1_ff;
         crd2_ff  <= crd1_ff;
      end
   end

   // ---------------- stage 3: blend coefficients ----------------
   logic [T_W-1:0]        cbh, ctah, ctbh;
   logic signed [C_W-1:0] ca3_in, cb3_in, cta3_in, ctb3_in;

   logic signed [C_W-1:0]     ca3_ff, cb3_ff, cta3_ff, ctb3_ff;
   logic signed [COORD_W-1:0] crd3_ff [NUM_COORD];

   always_comb begin
      cbh  = T_W'((pcb2_ff + (PK_W'(1) << (THETA_BITS - 1))) >> THETA_BITS);
      ctah = T_W'((pcta2_ff + (P_W'(1) << (THETA_BITS - 1))) >> THETA_BITS);
      ctbh = T_W'((pctb2_ff + (P_W'(1) << (THETA_BITS - 1))) >> THETA_BITS);
      ca3_in  = '0;
      cb3_in  = '0;
      cta3_in = '0;
      ctb3_in = '0;
      case (mode2_ff)
         MODE_HERMITE: begin
            cb3_in  = $signed({1'b0, cbh});
            ca3_in  = ONE_C - $signed({1'b0, cbh});
            cta3_in = $signed({1'b0, ctah});
            ctb3_in = -$signed({1'b0, ctbh});
         end
         MODE_START: begin
            cb3_in  = $signed({1'b0, tq2_ff});
            ca3_in  = ONE_C - $signed({1'b0, tq2_ff});
            cta3_in = $signed({1'b0, t2_ff}) - $signed({1'b0, tq2_ff});
         end
         MODE_END: begin
            ca3_in  = $signed({1'b0, uq2_ff});
            cb3_in  = ONE_C - $signed({1'b0, uq2_ff});
            ctb3_in = $signed({1'b0, uq2_ff}) - $signed({1'b0, u2_ff});
         end
         default: begin
            ca3_in = $signed({1'b0, u2_ff});
            cb3_in = $signed({1'b0, t2_ff});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         ca3_ff  <= ca3_in;
         cb3_ff  <= cb3_in;
         cta3_ff <= cta3_in;
         ctb3_ff <= ctb3_in;
         crd3_ff <= crd2_ff;
      end
   end

   // ---------------- stage 4: coordinate products, lane 0 = x, 1 = y ----------------
   logic signed [PR_W-1:0] prod4_ff [2][4];

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         for (int c = 0; c < 2; c++) begin
            prod4_ff[c][0] <= PR_W'(crd3_ff[PT_START + c]) * PR_W'(ca3_ff);
            prod4_ff[c][1] <= PR_W'(crd3_ff[PT_END + c]) * PR_W'(cb3_ff);
            prod4_ff[c][2] <= PR_W'(crd3_ff[PT_TS + c]) * PR_W'(cta3_ff);
            prod4_ff[c][3] <= PR_W'(crd3_ff[PT_TE + c]) * PR_W'(ctb3_ff);
         end
      end
   end

   // ---------------- stage 5: pair sums ----------------
   logic signed [PR_W:0] psum5_ff [2][2];

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         for (int c = 0; c < 2; c++) begin
            psum5_ff[c][0] <= (PR_W+1)'(prod4_ff[c][0]) + (PR_W+1)'(prod4_ff[c][1]);
            psum5_ff[c][1] <= (PR_W+1)'(prod4_ff[c][2]) + (PR_W+1)'(prod4_ff[c][3]);
         end
      end
   end

   // ---------------- stage 6: final sum, round half up, clip ----------------
   logic signed [S_W-1:0]     sum6 [2];
   logic [R_W-1:0]            rnd6 [2];
   logic [1:0]                sat6;
   logic [COORD_W-1:0]        pt6_in [2];

   logic [COORD_W-1:0] pt6_ff [2];
   logic               sat6_ff;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         sum6[c] = S_W'(psum5_ff[c][0]) + S_W'(psum5_ff[c][1])
                 + (S_W'(1) <<< (THETA_BITS - 1));
         rnd6[c] = sum6[c][S_W-1:THETA_BITS];
         // in range when all bits from the int32 sign up agree
         sat6[c] = !((&rnd6[c][R_W-1:COORD_W-1]) || !(|rnd6[c][R_W-1:COORD_W-1]));
         if (!sat6[c]) begin
            pt6_in[c] = rnd6[c][COORD_W-1:0];
         end else if (rnd6[c][R_W-1]) begin
            pt6_in[c] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            pt6_in[c] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         pt6_ff  <= pt6_in;
         sat6_ff <= |sat6;
      end
   end

   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = {pt6_ff[1], pt6_ff[0]};
   assign rsp_tuser  = sat6_ff;

   // ---------------- assertions ----------------
   `HEPE_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, vld_ff[0])
   `HEPE_ASSERT_SAME(a_coef_unity, vld_ff[2], (ca3_ff + cb3_ff) == ONE_C)
   `HEPE_ASSERT_SAME(a_coef_sign, vld_ff[2], !cta3_ff[C_W-1] && (ctb3_ff == '0 || ctb3_ff[C_W-1]))
   `HEPE_ASSERT_SAME(a_sat_bound, rsp_tvalid && sat6_ff,
      pt6_ff[0] == {1'b1, {(COORD_W-1){1'b0}}} || pt6_ff[0] == {1'b0, {(COORD_W-1){1'b1}}}
      || pt6_ff[1] == {1'b1, {(COORD_W-1){1'b0}}} || pt6_ff[1] == {1'b0, {(COORD_W-1){1'b1}}})

endmodule
